[rtl/core/sha1_pkg.sv]
// Package with the SHA-1 engine payload types, constants and round helpers.
`timescale 1ns / 1ps
package sha1_pkg;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   // Entry of the queue between the word packer and the compression core.
   typedef struct packed {
      logic [511:0] block;
      logic         final_block;
   } blk_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD,
      CORE_OUT
   } core_state_type;

   typedef enum logic [1:0] {
      PACK_IDLE,
      PACK_PAD,
      PACK_LEN
   } pack_state_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS = 6'd56;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20) f = d ^ (b & (c ^ d));
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (d & (b | c));
      else f = b ^ c ^ d;
      return f;
   endfunction

endpackage

[rtl/core/sha1_packer.sv]
// Front end: packs message bytes into 64-byte blocks and adds padding and length.
`timescale 1ns / 1ps
module sha1_packer import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_item,
   output logic    in_ready,
   output logic    blk_valid,
   output blk_type blk_item,
   input  logic    blk_ready
);

   logic [31:0]    buf_ff [16];
   logic [31:0]    buf_in [16];
   logic [5:0]     pos_ff, pos_in;
   logic [63:0]    count_ff, count_in;
   logic [63:0]    bits_ff, bits_in;
   pack_state_type state_ff, state_in;
   logic           emit;
   logic           emit_final;
   logic [511:0]   blk_bits;

   // One input word, or one padding step, per cycle. A step that fills the
   // block hands it to the queue; the step waits while the queue is full.
   always_comb begin
      logic [2:0]  n;
      logic [5:0]  p;
      logic [63:0] c;
      logic        fill;
      buf_in     = buf_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      bits_in    = bits_ff;
      state_in   = state_ff;
      emit       = 1'b0;
      emit_final = 1'b0;
      in_ready   = 1'b0;
      blk_bits   = '0;
      n = (in_item.valid_bytes > 3'd4) ? 3'd4 : in_item.valid_bytes;
      p = pos_ff;
      c = count_ff;
      fill = 1'b0;
      case (state_ff)
         PACK_IDLE: begin
            // The word may complete a block only if its bytes reach byte 63.
            in_ready = blk_ready || ({1'b0, pos_ff} + 7'd4 < 7'd64);
            if (in_valid && in_ready) begin
               for (int i = 0; i < 4; i++) begin
                  if (3'(i) < n) begin
                     buf_in[p[5:2]][31 - 8 * p[1:0] -: 8] =
                        in_item.message_word[31 - 8 * i -: 8];
                     if (p == 6'd63) begin
                        // Capture the full block before later bytes of the
                        // same word start the next one.
                        fill = 1'b1;
                        for (int k = 0; k < 16; k++)
                           blk_bits[511 - 32 * k -: 32] = buf_in[k];
                     end
                     p = p + 6'd1;
                     c = c + 64'd1;
                  end
               end
               pos_in   = p;
               count_in = c;
               emit     = fill;
               if (in_item.end_of_message) begin
                  bits_in  = {c[60:0], 3'b000};
                  state_in = PACK_PAD;
               end
            end
         end
         PACK_PAD: begin
            // Append the marker byte, then pad with zeros up to byte 56.
            if (blk_ready || pos_ff < LEN_POS) begin
               buf_in[pos_ff[5:2]][31 - 8 * pos_ff[1:0] -: 8] = PAD_BYTE;
               for (int j = 0; j < 64; j++)
                  if (6'(j) > pos_ff) buf_in[4'(j >> 2)][31 - 8 * (j & 3) -: 8] = 8'h00;
               if (pos_ff >= LEN_POS) begin
                  emit   = 1'b1;
                  pos_in = 6'd0;
               end else begin
                  pos_in = LEN_POS;
               end
               state_in = PACK_LEN;
            end
         end
         PACK_LEN: begin
            if (blk_ready) begin
               if (pos_ff == 6'd0)
                  for (int j = 0; j < 14; j++) buf_in[4'(j)] = 32'h0;
               buf_in[14] = bits_ff[63:32];
               buf_in[15] = bits_ff[31:0];
               emit       = 1'b1;
               emit_final = 1'b1;
               pos_in     = 6'd0;
               count_in   = 64'd0;
               state_in   = PACK_IDLE;
            end
         end
         default: state_in = PACK_IDLE;
      endcase
      if (!fill)
         for (int k = 0; k < 16; k++) blk_bits[511 - 32 * k -: 32] = buf_in[k];
      blk_valid = emit;
      blk_item.block = blk_bits;
      blk_item.final_block = emit_final;
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      bits_ff <= bits_in;
      if (reset) begin
         state_ff <= PACK_IDLE;
         pos_ff   <= 6'd0;
         count_ff <= 64'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/core/sha1_block_fifo.sv]
// Two-entry queue of complete blocks between the packer and the core.
`timescale 1ns / 1ps
module sha1_block_fifo import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  blk_type wr_item,
   output logic    wr_ready,
   output logic    rd_valid,
   output blk_type rd_item,
   input  logic    rd_take
);

   blk_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_item  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_item;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= ~wp_ff;
         if (rd_take && rd_valid) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_valid && wr_ready) - 2'(rd_take && rd_valid);
      end
   end

endmodule

[rtl/core/sha1_core.sv]
// Back end: 80-round compression, chaining update and digest output.
`timescale 1ns / 1ps
module sha1_core import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    blk_valid,
   input  blk_type blk_item,
   output logic    blk_take,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   core_state_type state_ff, state_in;
   logic [31:0] h_ff [5];
   logic [31:0] w_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  r_ff;
   logic [2:0]  o_ff;
   logic        fin_ff;
   logic [31:0] wx, x, t;
   logic        round_go;

   assign wx = w_ff[4'(r_ff - 7'd3)] ^ w_ff[4'(r_ff - 7'd8)] ^
               w_ff[4'(r_ff - 7'd14)] ^ w_ff[r_ff[3:0]];
   assign x = (r_ff < 7'd16) ? w_ff[r_ff[3:0]] : {wx[30:0], wx[31]};
   assign t = {a_ff[26:0], a_ff[31:27]} + round_f(r_ff, b_ff, c_ff, d_ff) + e_ff +
              round_k(r_ff) + x;

   always_comb begin
      state_in  = state_ff;
      blk_take  = 1'b0;
      round_go  = 1'b0;
      rsp_empty = 1'b1;
      rsp_data.digest_word = h_ff[o_ff];
      rsp_data.digest_last = (o_ff == 3'd4);
      case (state_ff)
         CORE_IDLE: if (blk_valid) begin
            blk_take = 1'b1;
            state_in = CORE_ROUND;
         end
         CORE_ROUND: begin
            round_go = 1'b1;
            if (r_ff == 7'd79) state_in = CORE_ADD;
         end
         CORE_ADD: state_in = fin_ff ? CORE_OUT : CORE_IDLE;
         CORE_OUT: begin
            rsp_empty = 1'b0;
            if (rsp_pop && o_ff == 3'd4) state_in = CORE_IDLE;
         end
         default: state_in = CORE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (blk_take) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= blk_item.block[511 - 32 * i -: 32];
         fin_ff <= blk_item.final_block;
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
         d_ff <= h_ff[3]; e_ff <= h_ff[4];
      end
      if (round_go) begin
         w_ff[r_ff[3:0]] <= x;
         a_ff <= t; b_ff <= a_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff; e_ff <= d_ff;
      end
      if (reset) begin
         state_ff <= CORE_IDLE;
         r_ff <= 7'd0;
         o_ff <= 3'd0;
         h_ff[0] <= IV0; h_ff[1] <= IV1; h_ff[2] <= IV2; h_ff[3] <= IV3; h_ff[4] <= IV4;
      end else begin
         state_ff <= state_in;
         if (round_go) r_ff <= (r_ff == 7'd79) ? 7'd0 : r_ff + 7'd1;
         if (state_ff == CORE_ADD) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
            h_ff[4] <= h_ff[4] + e_ff;
         end
         if (state_ff == CORE_OUT && rsp_pop) begin
            if (o_ff == 3'd4) begin
               o_ff <= 3'd0;
               h_ff[0] <= IV0; h_ff[1] <= IV1; h_ff[2] <= IV2;
               h_ff[3] <= IV3; h_ff[4] <= IV4;
            end else begin
               o_ff <= o_ff + 3'd1;
            end
         end
      end
   end

endmodule

[rtl/core/sha1_hash_engine.sv]
// Top level of the SHA-1 engine: packer, block queue and compression core.
`timescale 1ns / 1ps
//  Channel   Direction  Handshake          Payload
//  req_      in         push / full        message_word, valid_bytes, end_of_message
//  rsp_      out        empty / pop        digest_word, digest_last
//
// The packer writes each word straight into its block buffer; the core compresses
// one block at a time (load, 80 rounds with one round unit, chaining add), so the
// sustained rate is set by the round unit. A final word adds the packer's marker and
// length steps and one or two blocks, then the five digest words.
// Reset is synchronous and restores the initial chaining value and byte count.
// The two-entry block queue lets the packer keep taking words while the core
// works or while digest words wait to be popped.
module sha1_hash_engine import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   logic    in_ready;
   logic    pk_valid, pk_ready;
   blk_type pk_item;
   logic    q_valid, q_take;
   blk_type q_item;

   assign req_full = ~in_ready;

   sha1_packer u_packer (
      .clock, .reset,
      .in_valid (req_push), .in_item (req_data), .in_ready (in_ready),
      .blk_valid (pk_valid), .blk_item (pk_item), .blk_ready (pk_ready)
   );

   sha1_block_fifo u_fifo (
      .clock, .reset,
      .wr_valid (pk_valid), .wr_item (pk_item), .wr_ready (pk_ready),
      .rd_valid (q_valid), .rd_item (q_item), .rd_take (q_take)
   );

   sha1_core u_core (
      .clock, .reset,
      .blk_valid (q_valid), .blk_item (q_item), .blk_take (q_take),
      .rsp_empty, .rsp_data, .rsp_pop
   );

endmodule
